>>> sv/mbr_pkg.sv
// Shared constants for the MCU-to-raster reorder block.
// No dependencies; compiled before every other file.
package mbr_pkg;

    // 8x8 block geometry
    localparam int BLOCK_EDGE        = 8;
    localparam int BE_W              = 3;
    localparam int SAMPLES_PER_BLOCK = BLOCK_EDGE * BLOCK_EDGE;
    localparam int SIB_W             = 6;

    // sampling factor limits
    localparam int MAX_FACTOR_DEF    = 4;
    localparam int FACTOR_CFG_W      = 3;

    // MCU counters
    localparam int MCU_COL_LIMIT     = 8192;
    localparam int MCU_CNT_W         = 13;
    localparam int MC_W              = 14;

    // picture dimensions and payload
    localparam int DIM_W             = 16;
    localparam int PIX_W             = 8;
    localparam int ADDR_W            = 32;

    // configuration port
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MCU_COLUMNS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_H_FACTOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_V_FACTOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 3'd5;

endpackage

>>> sv/mbr_if.sv
// Channel interfaces: sample input, pixel output, configuration write.
// Depends on mbr_pkg.
interface mbr_in_if import mbr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             first_sample;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, first_sample, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, first_sample, red_in, green_in, blue_in, output ready);
endinterface

interface mbr_out_if import mbr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  red_out;
    logic [PIX_W-1:0]  green_out;
    logic [PIX_W-1:0]  blue_out;

    modport source (output valid, pixel_address, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, pixel_address, red_out, green_out, blue_out, output ready);
endinterface

interface mbr_cfg_if import mbr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/mbr_position.sv
// Sample, block and MCU position counters in MCU scan order.
// Depends on mbr_pkg.
module mbr_position import mbr_pkg::*; #(
    parameter int MAX_FACTOR = MAX_FACTOR_DEF,
    parameter int FW         = $clog2(MAX_FACTOR + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic                 i_first,
    input  logic [FW-1:0]        i_h,
    input  logic [FW-1:0]        i_v,
    input  logic [MC_W-1:0]      i_mc,
    output logic [SIB_W-1:0]     o_sib,
    output logic [FW-1:0]        o_bcol,
    output logic [FW-1:0]        o_brow,
    output logic [MCU_CNT_W-1:0] o_mcol,
    output logic [MCU_CNT_W-1:0] o_mrow
);

    logic [SIB_W-1:0]     r_sib,  n_sib;
    logic [FW-1:0]        r_bcol, n_bcol;
    logic [FW-1:0]        r_brow, n_brow;
    logic [MCU_CNT_W-1:0] r_mcol, n_mcol;
    logic [MCU_CNT_W-1:0] r_mrow, n_mrow;

    logic [FW-1:0]   bcol_inc;
    logic [FW-1:0]   brow_inc;
    logic [MC_W-1:0] mcol_inc;

    // restart the scan on the first sample of a picture
    assign o_sib  = i_first ? '0 : r_sib;
    assign o_bcol = i_first ? '0 : r_bcol;
    assign o_brow = i_first ? '0 : r_brow;
    assign o_mcol = i_first ? '0 : r_mcol;
    assign o_mrow = i_first ? '0 : r_mrow;

    assign bcol_inc = o_bcol + FW'(1);
    assign brow_inc = o_brow + FW'(1);
    assign mcol_inc = {1'b0, o_mcol} + MC_W'(1);

    always_comb begin
        n_sib  = r_sib;
        n_bcol = r_bcol;
        n_brow = r_brow;
        n_mcol = r_mcol;
        n_mrow = r_mrow;
        if (i_advance) begin
            n_sib  = o_sib + SIB_W'(1);
            n_bcol = o_bcol;
            n_brow = o_brow;
            n_mcol = o_mcol;
            n_mrow = o_mrow;
            if (o_sib == SIB_W'(SAMPLES_PER_BLOCK - 1)) begin
                if (bcol_inc < i_h) begin
                    n_bcol = bcol_inc;
                end else begin
                    n_bcol = '0;
                    if (brow_inc < i_v) begin
                        n_brow = brow_inc;
                    end else begin
                        n_brow = '0;
                        if (mcol_inc < i_mc) begin
                            n_mcol = mcol_inc[MCU_CNT_W-1:0];
                        end else begin
                            n_mcol = '0;
                            n_mrow = o_mrow + MCU_CNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sib  <= '0;
            r_bcol <= '0;
            r_brow <= '0;
            r_mcol <= '0;
            r_mrow <= '0;
        end else begin
            r_sib  <= n_sib;
            r_bcol <= n_bcol;
            r_brow <= n_brow;
            r_mcol <= n_mcol;
            r_mrow <= n_mrow;
        end
    end

endmodule

>>> sv/mcu_block_to_raster_reorder.sv
// Top level of the MCU-order to raster-order sample reorder.
// Depends on mbr_pkg, mbr_if and mbr_position.
//
// Use:
//   i_pix carries decoded samples, one word per sample, in MCU scan order:
//   64 samples of a block, blocks of an MCU across then down, MCUs across
//   the padded picture then down. first_sample restarts the scan.
//   o_pix carries one word per visible pixel: its raster address
//   (row * image_width + column) and the colour values. Samples beyond
//   the visible width or height produce no word but still advance the scan.
//   Grayscale mode passes luminance in red and zeroes green and blue.
//   i_cfg writes the registers by index; write only while the block is idle.
// Timing:
//   Four-stage pipeline: position capture, column/row and crop test,
//   16x16 address multiply, final add into the output register. Words
//   pass the stages in that order. One sample per cycle is taken
//   sustained while o_pix is ready; the position counter steps once
//   per accepted sample and sets the pace.
// Reset and stall:
//   Reset empties the pipeline, clears the scan position and restores the
//   register defaults (8x8 picture, one MCU, 1x1 factors, RGB). When o_pix
//   stalls the stages fill and hold; i_pix.ready drops only once all four
//   stages hold a word.
module mcu_block_to_raster_reorder import mbr_pkg::*; #(
    parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    mbr_in_if.sink       i_pix,
    mbr_out_if.source    o_pix,
    mbr_cfg_if.sink      i_cfg
);

    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int POS_W = $clog2(MCU_COL_LIMIT * MAX_FACTOR * BLOCK_EDGE);
    localparam int BW    = POS_W - BE_W;

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0] r_width, r_height;
    logic [MC_W-1:0]  r_mc;
    logic [FW-1:0]    r_h, r_v;
    logic             r_color;

    logic [FW-1:0]    n_factor;
    logic [MC_W-1:0]  n_mc;
    logic             cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    // clamp a sampling factor to 1..MAX_FACTOR at write time
    always_comb begin
        if (i_cfg.data[FACTOR_CFG_W-1:0] == '0) begin
            n_factor = FW'(1);
        end else if (32'(i_cfg.data[FACTOR_CFG_W-1:0]) > MAX_FACTOR) begin
            n_factor = FW'(MAX_FACTOR);
        end else begin
            n_factor = FW'(i_cfg.data[FACTOR_CFG_W-1:0]);
        end
    end

    // clamp MCU columns to 1..MCU_COL_LIMIT
    always_comb begin
        if (i_cfg.data[MC_W-1:0] == '0) begin
            n_mc = MC_W'(1);
        end else if (i_cfg.data[MC_W-1:0] > MC_W'(MCU_COL_LIMIT)) begin
            n_mc = MC_W'(MCU_COL_LIMIT);
        end else begin
            n_mc = i_cfg.data[MC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(8);
            r_height <= DIM_W'(8);
            r_mc     <= MC_W'(1);
            r_h      <= FW'(1);
            r_v      <= FW'(1);
            r_color  <= 1'b1;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg.data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg.data[DIM_W-1:0];
                CFG_MCU_COLUMNS:  r_mc     <= n_mc;
                CFG_H_FACTOR:     r_h      <= n_factor;
                CFG_V_FACTOR:     r_v      <= n_factor;
                CFG_COLOR_MODE:   r_color  <= i_cfg.data[0];
                default:          ;  // unmapped index: drop the write
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;
    logic in_acc;

    // a stage may load when it is empty or its word moves on
    assign s4_rdy      = !r_v4 || o_pix.ready;
    assign s3_rdy      = !r_v3 || s4_rdy;
    assign s2_rdy      = !r_v2 || s3_rdy;
    assign s1_rdy      = !r_v1 || s2_rdy;
    assign i_pix.ready = s1_rdy;
    assign in_acc      = i_pix.valid && i_pix.ready;

    // ---------------- stage 1: scan position ----------------
    logic [SIB_W-1:0]     pos_sib;
    logic [FW-1:0]        pos_bcol, pos_brow;
    logic [MCU_CNT_W-1:0] pos_mcol, pos_mrow;

    mbr_position #(
        .MAX_FACTOR (MAX_FACTOR),
        .FW         (FW)
    ) u_position (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_acc),
        .i_first   (i_pix.first_sample),
        .i_h       (r_h),
        .i_v       (r_v),
        .i_mc      (r_mc),
        .o_sib     (pos_sib),
        .o_bcol    (pos_bcol),
        .o_brow    (pos_brow),
        .o_mcol    (pos_mcol),
        .o_mrow    (pos_mrow)
    );

    logic [SIB_W-1:0]     r_sib1;
    logic [FW-1:0]        r_bcol1, r_brow1;
    logic [MCU_CNT_W-1:0] r_mcol1, r_mrow1;
    logic [PIX_W-1:0]     r_red1, r_grn1, r_blu1;

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_sib1  <= pos_sib;
            r_bcol1 <= pos_bcol;
            r_brow1 <= pos_brow;
            r_mcol1 <= pos_mcol;
            r_mrow1 <= pos_mrow;
            r_red1  <= i_pix.red_in;
            // grayscale: zero green and blue
            r_grn1  <= r_color ? i_pix.green_in : '0;
            r_blu1  <= r_color ? i_pix.blue_in  : '0;
        end
    end

    // ---------------- stage 2: column, row, crop ----------------
    logic [BW-1:0]    base_col, base_row;
    logic [POS_W-1:0] n_col2, n_row2;
    logic             keep;

    assign base_col = BW'(r_mcol1) * BW'(r_h) + BW'(r_bcol1);
    assign base_row = BW'(r_mrow1) * BW'(r_v) + BW'(r_brow1);
    assign n_col2   = {base_col, r_sib1[BE_W-1:0]};
    assign n_row2   = {base_row, r_sib1[SIB_W-1:BE_W]};
    assign keep     = (n_col2 < POS_W'(r_width)) && (n_row2 < POS_W'(r_height));

    // a kept pixel lies inside the picture, so both fit in DIM_W bits
    logic [DIM_W-1:0] r_col2, r_row2;
    logic [PIX_W-1:0] r_red2, r_grn2, r_blu2;

    always_ff @(posedge i_clk) begin
        if (s2_rdy) begin
            r_col2 <= n_col2[DIM_W-1:0];
            r_row2 <= n_row2[DIM_W-1:0];
            r_red2 <= r_red1;
            r_grn2 <= r_grn1;
            r_blu2 <= r_blu1;
        end
    end

    // ---------------- stage 3: row times width ----------------
    logic [ADDR_W-1:0] r_prod3;
    logic [DIM_W-1:0]  r_col3;
    logic [PIX_W-1:0]  r_red3, r_grn3, r_blu3;

    always_ff @(posedge i_clk) begin
        if (s3_rdy) begin
            r_prod3 <= ADDR_W'(r_row2) * ADDR_W'(r_width);
            r_col3  <= r_col2;
            r_red3  <= r_red2;
            r_grn3  <= r_grn2;
            r_blu3  <= r_blu2;
        end
    end

    // ---------------- stage 4: output register ----------------
    logic [ADDR_W-1:0] r_addr4;
    logic [PIX_W-1:0]  r_red4, r_grn4, r_blu4;

    always_ff @(posedge i_clk) begin
        if (s4_rdy) begin
            r_addr4 <= r_prod3 + ADDR_W'(r_col3);
            r_red4  <= r_red3;
            r_grn4  <= r_grn3;
            r_blu4  <= r_blu3;
        end
    end

    // valid bits; a cropped sample leaves a bubble in stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (s1_rdy) r_v1 <= in_acc;
            if (s2_rdy) r_v2 <= r_v1 && keep;
            if (s3_rdy) r_v3 <= r_v2;
            if (s4_rdy) r_v4 <= r_v3;
        end
    end

    assign o_pix.valid         = r_v4;
    assign o_pix.pixel_address = r_addr4;
    assign o_pix.red_out       = r_red4;
    assign o_pix.green_out     = r_grn4;
    assign o_pix.blue_out      = r_blu4;

    // ---------------- assertions ----------------
    a_crop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_col2 < r_width) && (r_row2 < r_height))
        else $error("pixel outside the picture reached the address stages");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && !o_pix.ready))
        else $error("input stalled while the pipeline had room");

    a_stage3_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !s4_rdy) |=> r_v3)
        else $error("stage 3 word lost during an output stall");

endmodule
